// ===== sv/lvp_pkg.sv =====
// ----------------------------------------------------------------------------
// lvp_pkg
// Shared types and constants of the last-value predictor.
// ----------------------------------------------------------------------------
package lvp_pkg;

  // Widths of the item fields.
  localparam int INSTR_ADDRESS_W = 48;
  localparam int ACTUAL_VALUE_W  = 64;
  localparam int CONF_CTR_W      = 4;

  // Configuration port layout.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_CONFIDENCE_MAX = 2'd0;

  // Reset value of the confidence limit.
  localparam logic [CONF_CTR_W-1:0] CONF_MAX_RESET = 4'd7;

  // One input item.
  typedef struct packed {
    logic [INSTR_ADDRESS_W-1:0] instr_address;
    logic [ACTUAL_VALUE_W-1:0]  dest_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                      table_hit;
    logic [ACTUAL_VALUE_W-1:0] predicted_value;
    logic                      prediction_correct;
    logic                      confident;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

// ===== sv/last_value_predictor.sv =====
// ----------------------------------------------------------------------------
// last_value_predictor
// Last-value predictor with a tagged confidence table, built around two
// synchronous memories, each with one read port and one write port.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears both tables one entry
// per cycle, up to the size of the larger table; the confidence limit can be
// written during that time. After that, an item is accepted when start is
// high and busy is low, and its result is strobed on out_valid for one cycle
// from the result register that follows the update state. The block takes no
// new item until the update state is over: the accept cycle reads both
// tables, the update state compares, updates and writes the entries back
// through the write ports. The receiver cannot stall the result.
module last_value_predictor #(
  parameter int CONF_ENTRIES  = 1024,
  parameter int VALUE_ENTRIES = 4096,
  parameter int ADDR_BITS     = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Item input.
  input  logic                                 start,
  output logic                                 busy,
  input  lvp_pkg::in_item_t                    in_item,
  // Result output.
  output logic                                 out_valid,
  output lvp_pkg::out_item_t                   out_item,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lvp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [lvp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [lvp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int CI_W  = (CONF_ENTRIES  > 1) ? $clog2(CONF_ENTRIES)  : 1;
  localparam int VI_W  = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;
  localparam int CLR_ENTRIES = (CONF_ENTRIES > VALUE_ENTRIES) ? CONF_ENTRIES : VALUE_ENTRIES;
  localparam int CLR_W = (CLR_ENTRIES > 1) ? $clog2(CLR_ENTRIES) : 1;
  localparam int EXT_W = ADDR_BITS + lvp_pkg::INSTR_ADDRESS_W;
  localparam int CTR_W = lvp_pkg::CONF_CTR_W;
  localparam int VAL_W = lvp_pkg::ACTUAL_VALUE_W;
  // Entry layouts: {valid, tag, counter} and {valid, tag, last value, present}.
  localparam int CONF_W = 1 + ADDR_BITS + CTR_W;
  localparam int VENT_W = 1 + ADDR_BITS + VAL_W + 1;
  localparam logic [CI_W-1:0] CONF_MASK  = CI_W'(CONF_ENTRIES - 1);
  localparam logic [VI_W-1:0] VALUE_MASK = VI_W'(VALUE_ENTRIES - 1);

  lvp_pkg::state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CTR_W-1:0] conf_max_r;
  logic             out_valid_r;
  lvp_pkg::out_item_t out_item_r;

  logic [ADDR_BITS-1:0] addr_r;
  logic [VAL_W-1:0]     actual_r;

  logic [EXT_W-1:0]     in_addr_ext;
  logic [ADDR_BITS-1:0] in_addr;
  logic                 accept;

  logic [CONF_W-1:0] conf_mem [CONF_ENTRIES];
  logic [VENT_W-1:0] value_mem [VALUE_ENTRIES];
  logic [CONF_W-1:0] conf_rd;
  logic [VENT_W-1:0] value_rd;
  logic [CI_W-1:0]   conf_ra, conf_wa;
  logic [VI_W-1:0]   value_ra, value_wa;
  logic              conf_we, value_we;
  logic [CONF_W-1:0] conf_wd;
  logic [VENT_W-1:0] value_wd;
  logic              clr_conf, clr_value;

  logic                 c_valid, v_valid, v_present;
  logic [ADDR_BITS-1:0] c_tag, v_tag;
  logic [CTR_W-1:0]     c_ctr, ctr_base, ctr_new;
  logic [VAL_W-1:0]     v_last, predicted;
  logic                 hit, match, confident;

  // Cut or widen the incoming address to the tag width.
  assign in_addr_ext = EXT_W'(in_item.instr_address);
  assign in_addr     = in_addr_ext[ADDR_BITS-1:0];
  assign accept      = start && (state_r == lvp_pkg::ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_max_r <= lvp_pkg::CONF_MAX_RESET;
    end else if (psel && penable && pwrite && (paddr == lvp_pkg::REG_CONFIDENCE_MAX)) begin
      conf_max_r <= pwdata[CTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      lvp_pkg::REG_CONFIDENCE_MAX: prdata = lvp_pkg::CFG_DATA_W'(conf_max_r);
      default:                     prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sequencer: clearing pass, then one item at a time.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      lvp_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CLR_W'(1);
        if (clr_idx_r == CLR_W'(CLR_ENTRIES - 1)) begin
          state_nxt = lvp_pkg::ST_IDLE;
        end
      end
      lvp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lvp_pkg::ST_LOOKUP;
        end
      end
      lvp_pkg::ST_LOOKUP: begin
        state_nxt = lvp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lvp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lvp_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  assign busy = (state_r != lvp_pkg::ST_IDLE);

  // Hold the accepted item for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r   <= in_addr;
      actual_r <= in_item.dest_value;
    end
  end

  // Read addresses come straight from the input so data is ready next cycle.
  assign conf_ra  = in_addr[CI_W-1:0] & CONF_MASK;
  assign value_ra = in_addr[VI_W-1:0] & VALUE_MASK;

  // Unpack the entries read for the item under update.
  assign {c_valid, c_tag, c_ctr}            = conf_rd;
  assign {v_valid, v_tag, v_last, v_present} = value_rd;

  // Lookup and counter update, all from the pre-update entries.
  always_comb begin
    hit       = c_valid && v_valid && (c_tag == addr_r) && (v_tag == addr_r);
    confident = c_valid && (c_ctr != '0);
    predicted = hit ? v_last : '0;
    // On a miss the entry restarts at zero before the comparison.
    ctr_base  = hit ? c_ctr : '0;
    match     = v_present && (predicted == actual_r);
    ctr_new   = ctr_base;
    if (match) begin
      if (ctr_base < conf_max_r) begin
        ctr_new = ctr_base + CTR_W'(1);
      end
    end else if (ctr_base != '0) begin
      ctr_new = ctr_base - CTR_W'(1);
    end
  end

  // Write ports: zeros during the clearing pass, updated entries otherwise.
  assign clr_conf  = ({1'b0, clr_idx_r} < (CLR_W + 1)'(CONF_ENTRIES));
  assign clr_value = ({1'b0, clr_idx_r} < (CLR_W + 1)'(VALUE_ENTRIES));

  always_comb begin
    if (state_r == lvp_pkg::ST_CLEAR) begin
      conf_we  = clr_conf;
      value_we = clr_value;
      conf_wa  = clr_idx_r[CI_W-1:0];
      value_wa = clr_idx_r[VI_W-1:0];
      conf_wd  = '0;
      value_wd = '0;
    end else begin
      conf_we  = (state_r == lvp_pkg::ST_LOOKUP);
      value_we = (state_r == lvp_pkg::ST_LOOKUP);
      conf_wa  = addr_r[CI_W-1:0] & CONF_MASK;
      value_wa = addr_r[VI_W-1:0] & VALUE_MASK;
      conf_wd  = {1'b1, addr_r, ctr_new};
      value_wd = {1'b1, addr_r, actual_r, 1'b1};
    end
  end

  // Confidence table.
  always_ff @(posedge clk) begin
    if (conf_we) begin
      conf_mem[conf_wa] <= conf_wd;
    end
    conf_rd <= conf_mem[conf_ra];
  end

  // Last-value table.
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_wa] <= value_wd;
    end
    value_rd <= value_mem[value_ra];
  end

  // Result register, strobed for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == lvp_pkg::ST_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lvp_pkg::ST_LOOKUP) begin
      out_item_r.table_hit          <= hit;
      out_item_r.predicted_value    <= predicted;
      out_item_r.prediction_correct <= hit && (predicted == actual_r);
      out_item_r.confident          <= confident;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every accepted item yields its result after the update state and the result register.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item produced no result");

  // A result only follows an update cycle.
  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == lvp_pkg::ST_LOOKUP))
    else $error("result strobe without an update cycle");

  // Results never come in consecutive cycles.
  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // No item is taken while the tables are being cleared.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lvp_pkg::ST_CLEAR) |-> busy)
    else $error("clearing pass not holding off items");

endmodule
